FILE: src/bpc_pkg.sv
`default_nettype none

package bpc_pkg;

    localparam int unsigned TIME_W   = 32;
    localparam int unsigned LED_W    = 16;
    localparam int unsigned PERIOD_W = 16;
    localparam int unsigned DEB_W    = 8;
    localparam int unsigned LONG_W   = 16;
    localparam int unsigned IDX_W    = 3;
    localparam int unsigned CFG_W    = 16;
    localparam int unsigned IN_DATA_W  = 40;
    localparam int unsigned OUT_DATA_W = 24;

    // Register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_BLINK_EN     = 3'd0,
        REG_LED_MASK     = 3'd1,
        REG_BLINK_PERIOD = 3'd2,
        REG_DEBOUNCE     = 3'd3,
        REG_LONG_PRESS   = 3'd4,
        REG_ACTIVE_HIGH  = 3'd5
    } reg_index_t;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_SHORT = 2'd1,
        EV_LONG  = 2'd2
    } press_event_t;

    localparam logic [PERIOD_W-1:0] BLINK_PERIOD_RST = PERIOD_W'(125);
    localparam logic [DEB_W-1:0]    DEBOUNCE_RST     = DEB_W'(10);
    localparam logic [LONG_W-1:0]   LONG_PRESS_RST   = LONG_W'(500);
    localparam logic [LED_W-1:0]    LED_ALL          = '1;

    typedef struct packed {
        logic                blink_en;
        logic [LED_W-1:0]    led_mask;
        logic [PERIOD_W-1:0] blink_period_ms;
        logic [DEB_W-1:0]    debounce_ms;
        logic [LONG_W-1:0]   long_press_ms;
        logic                active_high;
    } cfg_t;

endpackage

`default_nettype wire

FILE: src/button_press_classifier_led_blink.sv
`default_nettype none

// Debounced push-button short/long press detector with a blinking LED word.
// Each input transaction carries a millisecond timestamp and the raw button
// level; each one yields exactly one output transaction holding the LED word
// (led_mask gated by the blink phase) and a press event (none, short, long).
// A level change is taken once it has differed for more than debounce_ms;
// a release held at least long_press_ms is a long press. All time differences
// wrap modulo 2^32. Throughput is one transaction per clock while the sink is
// ready: the item sits in an input register, the blink and debounce state is
// updated from it (one 32-bit subtract and compare per state element), and the
// result lands in an output register, which drives tvalid; a stalled sink
// holds the result there. The output register lets a new input be taken while
// a result still waits. Configuration writes take effect at the next edge and
// are meant to be issued while no transaction is in flight; writing
// blink_en = 0 sets the blink phase back to on.
module button_press_classifier_led_blink (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // configuration
    input  wire logic                            cfg_wr_en,
    input  wire logic [bpc_pkg::IDX_W-1:0]       cfg_index,
    input  wire logic [bpc_pkg::CFG_W-1:0]       cfg_wdata,
    // input stream
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [bpc_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // [31:0] now_ms, [32] button_level
    // output stream
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [bpc_pkg::OUT_DATA_W-1:0]       m_axis_tdata   // [15:0] led_word, [17:16] press_event
);
    import bpc_pkg::*;

    cfg_t              cfg_reg;
    logic              force_on;

    logic              in_valid_reg;
    logic [TIME_W-1:0] now_reg;
    logic              level_reg;
    logic              in_accept;
    logic              advance;

    logic              out_valid_reg;
    logic [LED_W-1:0]  led_word_reg;
    press_event_t      event_reg;

    logic              blink_on_next;
    press_event_t      press_event;

    // ---------------- configuration registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.blink_en        <= 1'b0;
            cfg_reg.led_mask        <= '0;
            cfg_reg.blink_period_ms <= BLINK_PERIOD_RST;
            cfg_reg.debounce_ms     <= DEBOUNCE_RST;
            cfg_reg.long_press_ms   <= LONG_PRESS_RST;
            cfg_reg.active_high     <= 1'b1;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_BLINK_EN:     cfg_reg.blink_en        <= cfg_wdata[0];
                REG_LED_MASK:     cfg_reg.led_mask        <= cfg_wdata[LED_W-1:0];
                REG_BLINK_PERIOD: cfg_reg.blink_period_ms <= cfg_wdata[PERIOD_W-1:0];
                REG_DEBOUNCE:     cfg_reg.debounce_ms     <= cfg_wdata[DEB_W-1:0];
                REG_LONG_PRESS:   cfg_reg.long_press_ms   <= cfg_wdata[LONG_W-1:0];
                REG_ACTIVE_HIGH:  cfg_reg.active_high     <= cfg_wdata[0];
                default:          ;
            endcase
        end
    end

    // disabling blink forces the phase back on
    assign force_on = cfg_wr_en && (cfg_index == REG_BLINK_EN) && !cfg_wdata[0];

    // ---------------- handshake ----------------
    // advance: the held item is processed and moves to the output register
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            now_reg   <= s_axis_tdata[TIME_W-1:0];
            level_reg <= s_axis_tdata[TIME_W];
        end
    end

    // ---------------- state units ----------------
    bpc_blink u_blink (
        .clk             (clk),
        .rst_n           (rst_n),
        .fire            (advance),
        .now_ms          (now_reg),
        .blink_en        (cfg_reg.blink_en),
        .blink_period_ms (cfg_reg.blink_period_ms),
        .force_on        (force_on),
        .blink_on_next   (blink_on_next)
    );

    bpc_button u_button (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (advance),
        .now_ms        (now_reg),
        .button_level  (level_reg),
        .debounce_ms   (cfg_reg.debounce_ms),
        .long_press_ms (cfg_reg.long_press_ms),
        .active_high   (cfg_reg.active_high),
        .press_event   (press_event)
    );

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            led_word_reg <= cfg_reg.led_mask & (blink_on_next ? LED_ALL : '0);
            event_reg    <= press_event;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W-LED_W-2){1'b0}}, event_reg, led_word_reg};

    // ---------------- assertions ----------------
    // a processed item always lands in the output register
    a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("processed item did not reach output register");

    // press event code 3 is never produced
    a_event_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (event_reg == EV_NONE || event_reg == EV_SHORT
                           || event_reg == EV_LONG))
        else $error("illegal press event code");

    // with blinking off the LED word is the plain mask
    a_steady_word: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !cfg_reg.blink_en && !force_on)
            |=> led_word_reg == $past(cfg_reg.led_mask))
        else $error("LED word differs from mask while blink disabled");

    // input stalls only while an item is held
    a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (in_valid_reg && out_valid_reg))
        else $error("input stalled with free pipeline");

endmodule

`default_nettype wire

FILE: src/bpc_blink.sv
`default_nettype none

// Blink phase: while enabled, toggles when more than the period has elapsed since the last toggle; force_on sets it on.
module bpc_blink (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         fire,
    input  wire logic [bpc_pkg::TIME_W-1:0]   now_ms,
    input  wire logic                         blink_en,
    input  wire logic [bpc_pkg::PERIOD_W-1:0] blink_period_ms,
    input  wire logic                         force_on,
    output logic                              blink_on_next
);
    import bpc_pkg::*;

    logic              blink_on_reg;
    logic [TIME_W-1:0] last_toggle_reg;
    logic [TIME_W-1:0] last_toggle_next;
    logic [TIME_W-1:0] elapsed;
    logic              toggle;

    always_comb
    begin
        elapsed          = now_ms - last_toggle_reg;
        toggle           = blink_en && (elapsed > {{(TIME_W-PERIOD_W){1'b0}}, blink_period_ms});
        blink_on_next    = toggle ? ~blink_on_reg : blink_on_reg;
        last_toggle_next = toggle ? now_ms : last_toggle_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blink_on_reg    <= 1'b1;
            last_toggle_reg <= '0;
        end
        else if (force_on)
        begin
            blink_on_reg <= 1'b1;
        end
        else if (fire)
        begin
            blink_on_reg    <= blink_on_next;
            last_toggle_reg <= last_toggle_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/bpc_button.sv
`default_nettype none

// Debounce and short/long press classification on release.
module bpc_button (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       fire,
    input  wire logic [bpc_pkg::TIME_W-1:0] now_ms,
    input  wire logic                       button_level,
    input  wire logic [bpc_pkg::DEB_W-1:0]  debounce_ms,
    input  wire logic [bpc_pkg::LONG_W-1:0] long_press_ms,
    input  wire logic                       active_high,
    output bpc_pkg::press_event_t           press_event
);
    import bpc_pkg::*;

    logic              stable_reg;
    logic              stable_next;
    logic [TIME_W-1:0] agree_reg;
    logic [TIME_W-1:0] agree_next;
    logic [TIME_W-1:0] start_reg;
    logic [TIME_W-1:0] start_next;
    logic [TIME_W-1:0] since_agree;
    logic [TIME_W-1:0] held;

    always_comb
    begin
        since_agree = now_ms - agree_reg;
        held        = now_ms - start_reg;
        stable_next = stable_reg;
        agree_next  = agree_reg;
        start_next  = start_reg;
        press_event = EV_NONE;
        if ((since_agree > {{(TIME_W-DEB_W){1'b0}}, debounce_ms}) && (button_level != stable_reg))
        begin
            stable_next = button_level;
            if (button_level == active_high)
            begin
                start_next = now_ms;
            end
            else if (held < {{(TIME_W-LONG_W){1'b0}}, long_press_ms})
            begin
                press_event = EV_SHORT;
            end
            else
            begin
                press_event = EV_LONG;
            end
        end
        else if (button_level == stable_reg)
        begin
            agree_next = now_ms;
        end
    end

    // stable level resets to the inactive level of the reset polarity (active high)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_reg <= 1'b0;
            agree_reg  <= '0;
            start_reg  <= '0;
        end
        else if (fire)
        begin
            stable_reg <= stable_next;
            agree_reg  <= agree_next;
            start_reg  <= start_next;
        end
    end

endmodule

`default_nettype wire

FILE: tb/tb_button_press_classifier_led_blink.sv
// Self-checking bench for the debounced button classifier with blinking LED word.
module tb_button_press_classifier_led_blink;
    timeunit 1ns;
    timeprecision 1ps;

    import bpc_pkg::*;

    // ------------------------------------------------------------------
    // Bench constants
    // ------------------------------------------------------------------
    localparam int unsigned ITEM_TARGET  = 1400;      // random ticks to send
    localparam int unsigned HOLD_CYCLES  = 300;       // long output back-pressure stretch
    localparam int unsigned DRAIN_CYCLES = 4;         // DUT holds at most two items, keep margin
    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int unsigned MAX_REPORTS  = 10;

    // Indexes past the last register; writes there must be ignored.
    localparam logic [IDX_W-1:0] REG_SPARE_6 = IDX_W'(6);
    localparam logic [IDX_W-1:0] REG_SPARE_7 = IDX_W'(7);

    typedef struct {
        logic [TIME_W-1:0] now;
        logic              level;
    } tick_t;

    typedef struct {
        logic [LED_W-1:0] led;
        press_event_t     ev;
    } led_status_t;

    // ------------------------------------------------------------------
    // Clock, reset and DUT ports
    // ------------------------------------------------------------------
    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  cfg_wr_en     = 1'b0;
    logic [IDX_W-1:0]      cfg_index     = '0;
    logic [CFG_W-1:0]      cfg_wdata     = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;   // [31:0] now_ms, [32] button_level
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;         // [15:0] led_word, [17:16] press_event

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    button_press_classifier_led_blink u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    tick_t       tick_backlog[$];     // ticks waiting for the driver
    led_status_t led_status_due[$];   // predicted output transactions, oldest first

    logic [TIME_W-1:0] stamp_ms;      // running timestamp for generated ticks
    int unsigned n_queued   = 0;
    int unsigned n_taken    = 0;
    int unsigned n_checked  = 0;
    int unsigned n_short    = 0;
    int unsigned n_long     = 0;
    int unsigned n_toggles  = 0;
    int unsigned n_settings = 0;
    int unsigned n_mismatch = 0;
    int unsigned cycle_count = 0;

    // idle shaping: enables set by the stimulus process, counters run by driver and sink
    logic        src_gaps_on  = 1'b0;
    logic        snk_stall_on = 1'b0;
    logic        hold_req     = 1'b0;
    int unsigned src_gap   = 0;
    int unsigned snk_wait  = 0;
    int unsigned hold_left = 0;

    // Predictor copy of the registers and of the tracking state
    cfg_t              mdl_cfg;
    logic              blink_phase;
    logic [TIME_W-1:0] toggle_stamp;
    logic [TIME_W-1:0] agree_stamp;
    logic [TIME_W-1:0] press_stamp;
    logic              deb_level;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void model_write(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        case (idx)
            REG_BLINK_EN:
            begin
                mdl_cfg.blink_en = val[0];
                // disabling blink parks the phase at on
                if (!val[0])
                    blink_phase = 1'b1;
            end
            REG_LED_MASK:     mdl_cfg.led_mask        = val[LED_W-1:0];
            REG_BLINK_PERIOD: mdl_cfg.blink_period_ms = val[PERIOD_W-1:0];
            REG_DEBOUNCE:     mdl_cfg.debounce_ms     = val[DEB_W-1:0];
            REG_LONG_PRESS:   mdl_cfg.long_press_ms   = val[LONG_W-1:0];
            // the debounced level is left alone on a polarity change
            REG_ACTIVE_HIGH:  mdl_cfg.active_high     = val[0];
            default: ;
        endcase
    endfunction

    // One service tick: blink update, LED word, then the debounce/press logic.
    // All differences are 32-bit and wrap.
    function automatic void predict_led_status(logic [TIME_W-1:0] now, logic level);
        led_status_t       r;
        logic [TIME_W-1:0] held;
        r.ev = EV_NONE;
        if (mdl_cfg.blink_en && (now - toggle_stamp) > mdl_cfg.blink_period_ms)
        begin
            blink_phase  = ~blink_phase;
            toggle_stamp = now;
            n_toggles++;
        end
        r.led = blink_phase ? mdl_cfg.led_mask : '0;

        if ((now - agree_stamp) > mdl_cfg.debounce_ms && level != deb_level)
        begin
            deb_level = level;
            if (deb_level == mdl_cfg.active_high)
                press_stamp = now;
            else
            begin
                held = now - press_stamp;
                // held exactly at the limit is long
                r.ev = (held < mdl_cfg.long_press_ms) ? EV_SHORT : EV_LONG;
                if (r.ev == EV_SHORT)
                    n_short++;
                else
                    n_long++;
            end
        end
        else if (level == deb_level)
            agree_stamp = now;
        led_status_due.push_back(r);
    endfunction

    function automatic void flag_mismatch(string what);
        n_mismatch++;
        if (n_mismatch <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, what);
    endfunction

    // Gap length: mostly none, some short, a few long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Register value: zero, the top, a small value or anything in range.
    function automatic int unsigned pick_span(int unsigned top, int unsigned low_top);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return 0;
        if (r < 30)
            return top;
        if (r < 70)
            return $urandom_range(0, low_top);
        return $urandom_range(0, top);
    endfunction

    // ------------------------------------------------------------------
    // Tick generation
    // ------------------------------------------------------------------
    function automatic void push_tick(logic [TIME_W-1:0] now, logic level);
        tick_t t;
        t.now   = now;
        t.level = level;
        stamp_ms = now;
        tick_backlog.push_back(t);
        n_queued++;
    endfunction

    function automatic void add_tick(int unsigned delta, logic level);
        push_tick(stamp_ms + TIME_W'(delta), level);
    endfunction

    // A well-formed press: idle samples, optional bounce, a pressed stretch that
    // covers debounce plus hold, then a released stretch past the debounce time.
    function automatic void queue_press(int unsigned hold_ms, int unsigned step_max);
        int unsigned span;
        int unsigned d;
        int unsigned deb;
        logic        pl;
        pl  = mdl_cfg.active_high;
        deb = mdl_cfg.debounce_ms;
        repeat ($urandom_range(1, 3))
            add_tick($urandom_range(1, step_max), ~pl);
        if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 4))
                add_tick($urandom_range(0, 2), 1'($urandom_range(0, 1)));
        span = 0;
        while (span <= hold_ms + deb)
        begin
            d = $urandom_range(1, step_max);
            add_tick(d, pl);
            span += d;
        end
        span = 0;
        while (span <= deb)
        begin
            d = $urandom_range(1, step_max);
            add_tick(d, ~pl);
            span += d;
        end
    endfunction

    // Random levels, random steps, now and then a jump to any timestamp.
    function automatic void queue_noise(int unsigned n, int unsigned step_max);
        repeat (n)
        begin
            if ($urandom_range(0, 7) == 0)
                push_tick($urandom(), 1'($urandom_range(0, 1)));
            else
                add_tick($urandom_range(0, step_max), 1'($urandom_range(0, 1)));
        end
    endfunction

    // ------------------------------------------------------------------
    // Configuration and phase control (stimulus process only)
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        // nothing in flight, so the predictor can take it right away
        model_write(idx, val);
    endtask

    // Block is idle once every tick went in and every result came out;
    // then allow the pipeline latency before touching registers.
    task automatic wait_idle();
        while (tick_backlog.size() != 0 || s_axis_tvalid || led_status_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Driver: input transactions from the backlog, with random gaps
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : driver
        tick_t nxt;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            src_gap       <= 0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (src_gap != 0)
            begin
                src_gap       <= src_gap - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (tick_backlog.size() != 0)
            begin
                nxt = tick_backlog.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= IN_DATA_W'({nxt.level, nxt.now});
                src_gap       <= src_gaps_on ? pick_gap() : 0;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Sink ready: random stalls plus the long hold-off
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_req)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            snk_wait      <= 0;
        end
        else if (hold_left != 0)
            m_axis_tready <= 1'b0;
        else if (snk_wait != 0)
        begin
            snk_wait      <= snk_wait - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            snk_wait      <= snk_stall_on ? pick_gap() : 0;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on each input transaction, check each output one.
    // Prediction comes first so the order inside a time step cannot matter.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        led_status_t due;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_led_status(s_axis_tdata[TIME_W-1:0], s_axis_tdata[TIME_W]);
                n_taken++;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (led_status_due.size() == 0)
                    flag_mismatch($sformatf("unexpected output transaction tdata=%h",
                                            m_axis_tdata));
                else
                begin
                    due = led_status_due.pop_front();
                    n_checked++;
                    if (m_axis_tdata[LED_W-1:0] !== due.led)
                        flag_mismatch($sformatf("led_word exp %h got %h",
                                                due.led, m_axis_tdata[LED_W-1:0]));
                    if (m_axis_tdata[LED_W+1:LED_W] !== due.ev)
                        flag_mismatch($sformatf("press_event exp %s got %0d",
                                                due.ev.name(), m_axis_tdata[LED_W+1:LED_W]));
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("button_press_classifier_led_blink regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int unsigned phase;
        int unsigned kind;
        int unsigned quota;
        int unsigned long_ms;
        int unsigned deb;
        int unsigned step;
        int unsigned hold;
        int unsigned r;

        // predictor reset state
        mdl_cfg.blink_en        = 1'b0;
        mdl_cfg.led_mask        = '0;
        mdl_cfg.blink_period_ms = BLINK_PERIOD_RST;
        mdl_cfg.debounce_ms     = DEBOUNCE_RST;
        mdl_cfg.long_press_ms   = LONG_PRESS_RST;
        mdl_cfg.active_high     = 1'b1;
        blink_phase  = 1'b1;
        toggle_stamp = '0;
        agree_stamp  = '0;
        press_stamp  = '0;
        deb_level    = ~mdl_cfg.active_high;
        stamp_ms     = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // --- directed: zero blink period and debounce, exact long limit, wrap
        write_reg(REG_LED_MASK, 16'hFFFF);
        write_reg(REG_BLINK_EN, 16'h0001);
        write_reg(REG_BLINK_PERIOD, 16'h0000);
        write_reg(REG_DEBOUNCE, 16'h0000);
        write_reg(REG_LONG_PRESS, 16'd5);
        write_reg(REG_ACTIVE_HIGH, 16'h0001);
        n_settings++;
        @(negedge clk);
        push_tick(32'd0, 1'b0);
        push_tick(32'd1, 1'b1);            // press at 1
        push_tick(32'd6, 1'b0);            // held exactly 5: long
        push_tick(32'd7, 1'b1);
        push_tick(32'd11, 1'b0);           // held 4: short
        push_tick(32'd11, 1'b0);           // same stamp, no toggle
        push_tick(32'hFFFF_FFFF, 1'b1);    // press at the top of the range
        push_tick(32'd3, 1'b0);            // wrapped duration 4: short
        wait_idle();

        // --- directed: top periods, masked debounce value, ignored index
        write_reg(REG_DEBOUNCE, 16'h12FF);      // upper byte dropped -> 255
        write_reg(REG_BLINK_PERIOD, 16'hFFFF);
        write_reg(REG_LONG_PRESS, 16'hFFFF);
        write_reg(REG_LED_MASK, 16'hA5A5);
        write_reg(REG_SPARE_6, 16'h0000);
        n_settings++;
        @(negedge clk);
        push_tick(32'd1000, 1'b0);
        push_tick(32'd1100, 1'b1);              // bounce inside debounce: ignored
        push_tick(32'd1200, 1'b0);
        push_tick(32'd1456, 1'b1);              // 256 ms after agreement: press
        push_tick(32'd66991, 1'b0);             // held 65535: long at the limit
        push_tick(32'd132527, 1'b1);
        push_tick(32'd132827, 1'b1);
        push_tick(32'd132867, 1'b0);            // within debounce: nothing
        wait_idle();

        // --- directed: polarity flip after reset, blink off, zero long limit
        write_reg(REG_BLINK_EN, 16'hFFFE);      // bit 0 clear: phase forced on
        write_reg(REG_DEBOUNCE, 16'd2);
        write_reg(REG_LONG_PRESS, 16'd0);
        write_reg(REG_ACTIVE_HIGH, 16'h0000);
        write_reg(REG_SPARE_7, 16'hFFFF);
        n_settings++;
        @(negedge clk);
        push_tick(32'd132877, 1'b0);
        push_tick(32'd132878, 1'b1);
        push_tick(32'd132880, 1'b0);
        wait_idle();

        // --- directed: re-enable blink with a short period
        write_reg(REG_BLINK_EN, 16'h0001);
        write_reg(REG_BLINK_EN, 16'h0001);      // writing 1 again changes nothing
        write_reg(REG_BLINK_PERIOD, 16'd3);
        write_reg(REG_LED_MASK, 16'h8001);
        n_settings++;
        @(negedge clk);
        repeat (4)
            add_tick(2, 1'($urandom_range(0, 1)));
        wait_idle();

        // --- random phases; the first two pin every register at an extreme, but for the random LED mask of the second
        n_queued = 0;
        phase    = 0;
        while (n_queued < ITEM_TARGET)
        begin
            kind = (phase < 2) ? phase : 2;
            if (kind == 0)
            begin
                write_reg(REG_BLINK_EN, 16'h0001);
                write_reg(REG_LED_MASK, 16'hFFFF);
                write_reg(REG_BLINK_PERIOD, 16'hFFFF);
                write_reg(REG_DEBOUNCE, 16'h00FF);
                write_reg(REG_LONG_PRESS, 16'hFFFF);
                write_reg(REG_ACTIVE_HIGH, 16'h0001);
            end
            else if (kind == 1)
            begin
                write_reg(REG_BLINK_EN, 16'h0001);
                write_reg(REG_LED_MASK, CFG_W'($urandom()));
                write_reg(REG_BLINK_PERIOD, 16'h0000);
                write_reg(REG_DEBOUNCE, 16'h0000);
                write_reg(REG_LONG_PRESS, 16'h0000);
                write_reg(REG_ACTIVE_HIGH, 16'h0000);
            end
            else
            begin
                write_reg(REG_BLINK_EN, CFG_W'($urandom()));
                r = $urandom_range(0, 3);
                write_reg(REG_LED_MASK, (r == 0) ? 16'h0000 :
                                        (r == 1) ? 16'hFFFF : CFG_W'($urandom()));
                write_reg(REG_BLINK_PERIOD, CFG_W'(pick_span(65535, 60)));
                write_reg(REG_DEBOUNCE, {8'($urandom()), 8'(pick_span(255, 30))});
                write_reg(REG_LONG_PRESS, CFG_W'(pick_span(65535, 2000)));
                if ($urandom_range(0, 3) == 0)
                    write_reg(REG_ACTIVE_HIGH, CFG_W'($urandom()));
                if ($urandom_range(0, 3) == 0)
                    write_reg($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7,
                              CFG_W'($urandom()));
            end
            n_settings++;

            long_ms = mdl_cfg.long_press_ms;
            deb     = mdl_cfg.debounce_ms;
            step    = (long_ms + deb) / 8 + 1;

            // sometimes restart the timestamp anywhere, or just below the wrap
            r = $urandom_range(0, 5);
            if (r == 0)
                stamp_ms = $urandom();
            else if (r == 1)
                stamp_ms = 32'hFFFF_FFFF - TIME_W'(4 * step);

            @(negedge clk);
            // phase 3 runs the back-pressure test: source flat out, sink frozen
            src_gaps_on  = (phase != 3) && ($urandom_range(0, 3) != 0);
            snk_stall_on = (phase != 3) && ($urandom_range(0, 3) != 0);

            quota = n_queued + $urandom_range(90, 140);
            while (n_queued < quota)
            begin
                if ($urandom_range(0, 4) == 0)
                    queue_noise($urandom_range(1, 4), step);
                else
                begin
                    r = $urandom_range(0, 9);
                    if (r < 4)
                        hold = $urandom_range(0, long_ms);
                    else if (r < 8)
                        hold = long_ms + $urandom_range(0, long_ms / 2 + 5);
                    else if (long_ms > 2)
                        hold = long_ms - 2 + $urandom_range(0, 4);
                    else
                        hold = $urandom_range(0, 4);
                    queue_press(hold, step);
                end
            end

            if (phase == 3)
            begin
                hold_req = 1'b1;
                @(negedge clk);
                hold_req = 1'b0;
            end
            wait_idle();
            phase++;
        end

        wait_idle();
        $display("covered %0d ticks over %0d register settings, %0d LED words checked",
                 n_taken, n_settings, n_checked);
        $display("releases seen: %0d short, %0d long; %0d blink toggles; %0d mismatches",
                 n_short, n_long, n_toggles, n_mismatch);
        if (n_mismatch == 0 && led_status_due.size() == 0)
            $display("button_press_classifier_led_blink regression: pass");
        else
            $display("button_press_classifier_led_blink regression: fail");
        $finish;
    end

endmodule

FILE: sim.f
src/bpc_pkg.sv
src/bpc_blink.sv
src/bpc_button.sv
src/button_press_classifier_led_blink.sv
tb/tb_button_press_classifier_led_blink.sv
